// ----- design/soalu_pkg.sv -----
// ----------------------------------------------------------------------------
// soalu_pkg: shared types and constants of the signed octal ALU
// Operation codes, status codes and the item record that travels the queue.
// ----------------------------------------------------------------------------
package soalu_pkg;

  localparam int MAG_W      = 24;
  localparam int DIGITS_DEF = 8;
  localparam int QDEPTH_DEF = 2;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_WHOLE    = 2'd3
  } status_t;

  // Classified item: the front resolves everything except multiply and divide by a nonzero divisor.
  typedef struct packed {
    op_t              op;
    status_t          status;
    logic             neg;
    logic [MAG_W-1:0] mag;
    logic [MAG_W-1:0] a_mag;
    logic [MAG_W-1:0] b_mag;
    logic             a_neg;
    logic             b_neg;
  } item_t;

endpackage

// ----- design/signed_octal_alu.sv -----
// ----------------------------------------------------------------------------
// signed_octal_alu: sign-magnitude octal ALU
// Add, subtract, multiply and divide on eight-digit octal magnitudes.
// ----------------------------------------------------------------------------
//
//  channel | handshake      | fields
//  --------+----------------+------------------------------------------------
//  input   | valid / ready  | kind, a_negative, a_magnitude, b_negative,
//          |                | b_magnitude
//  output  | out_valid /    | status, result_negative, result_magnitude,
//          | out_ready      | remainder_magnitude
//
// One item is accepted per cycle while the output is not stalled. The path runs
// through one front register, the queue, and the back pipeline: a multiply
// stage, the 24 restoring division stages and the output register, where the
// sign fixup lands.
// Synchronous reset empties the front register, the queue and the pipeline.
// A stalled output holds the back pipeline; the queue then absorbs items
// already in flight from the front before the input ready drops.
// ----------------------------------------------------------------------------
module signed_octal_alu #(
  parameter int DIGITS = soalu_pkg::DIGITS_DEF,
  parameter int QDEPTH = soalu_pkg::QDEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        valid,
  output logic                        ready,
  input  logic [1:0]                  kind,
  input  logic                        a_negative,
  input  logic [soalu_pkg::MAG_W-1:0] a_magnitude,
  input  logic                        b_negative,
  input  logic [soalu_pkg::MAG_W-1:0] b_magnitude,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  status,
  output logic                        result_negative,
  output logic [soalu_pkg::MAG_W-1:0] result_magnitude,
  output logic [soalu_pkg::MAG_W-1:0] remainder_magnitude
);

  logic             fq_valid, fq_ready, qb_valid, qb_ready;
  soalu_pkg::item_t fq_item, qb_item;

  // Front: range check, add/subtract, divide-by-zero classification.
  soalu_front #(.DIGITS(DIGITS)) u_front (
    .clk, .rst, .valid, .ready, .kind, .a_negative, .a_magnitude,
    .b_negative, .b_magnitude,
    .q_valid(fq_valid), .q_ready(fq_ready), .q_item(fq_item)
  );

  soalu_fifo #(.DEPTH(QDEPTH)) u_fifo (
    .clk, .rst,
    .in_valid(fq_valid), .in_ready(fq_ready), .in_item(fq_item),
    .out_valid(qb_valid), .out_ready(qb_ready), .out_item(qb_item)
  );

  // Back: multiplier, pipelined divider and sign fixup.
  soalu_back #(.DIGITS(DIGITS)) u_back (
    .clk, .rst,
    .in_valid(qb_valid), .in_ready(qb_ready), .in_item(qb_item),
    .valid(out_valid), .ready(out_ready),
    .status, .result_negative, .result_magnitude, .remainder_magnitude
  );

endmodule

// ----- design/soalu_front.sv -----
// ----------------------------------------------------------------------------
// soalu_front: input stage
// Accepts items, checks operand range, finishes add and subtract, and flags
// division by zero.
// ----------------------------------------------------------------------------
module soalu_front #(
  parameter int DIGITS = soalu_pkg::DIGITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       valid,
  output logic                       ready,
  input  logic [1:0]                 kind,
  input  logic                       a_negative,
  input  logic [soalu_pkg::MAG_W-1:0] a_magnitude,
  input  logic                       b_negative,
  input  logic [soalu_pkg::MAG_W-1:0] b_magnitude,
  output logic                       q_valid,
  input  logic                       q_ready,
  output soalu_pkg::item_t           q_item
);

  localparam int LW = 3 * DIGITS;
  // Compare width covers both the digit limit and the full port width.
  localparam int CW = ((LW > soalu_pkg::MAG_W) ? LW : soalu_pkg::MAG_W) + 1;
  localparam logic [CW-1:0] LIM = CW'({LW{1'b1}});

  soalu_pkg::item_t it;
  logic [CW-1:0] am, bm, sum;
  logic          bn;

  always_comb begin
    am  = CW'(a_magnitude);
    bm  = CW'(b_magnitude);
    bn  = (kind == soalu_pkg::OP_SUB) ? ~b_negative : b_negative;
    sum = am + bm;
    it        = '0;
    it.op     = soalu_pkg::op_t'(kind);
    it.a_mag  = a_magnitude;
    it.b_mag  = b_magnitude;
    it.a_neg  = a_negative;
    it.b_neg  = b_negative;
    it.status = soalu_pkg::ST_OK;
    if (am > LIM || bm > LIM) begin
      it.op     = soalu_pkg::OP_ADD;
      it.status = soalu_pkg::ST_OVERFLOW;
    end else if (kind == soalu_pkg::OP_ADD || kind == soalu_pkg::OP_SUB) begin
      it.op = soalu_pkg::OP_ADD;
      if (a_negative == bn) begin
        if (sum > LIM) it.status = soalu_pkg::ST_OVERFLOW;
        else begin
          it.neg = a_negative;
          it.mag = soalu_pkg::MAG_W'(sum);
        end
      end else if (a_magnitude >= b_magnitude) begin
        it.neg = a_negative;
        it.mag = a_magnitude - b_magnitude;
      end else begin
        it.neg = bn;
        it.mag = b_magnitude - a_magnitude;
      end
    end else if (kind == soalu_pkg::OP_DIV && b_magnitude == '0) begin
      it.op     = soalu_pkg::OP_ADD;
      it.status = (a_magnitude == '0) ? soalu_pkg::ST_WHOLE : soalu_pkg::ST_EMPTY;
    end
    if (it.mag == '0) it.neg = 1'b0;
  end

  assign ready = ~q_valid | q_ready;

  always_ff @(posedge clk) begin
    if (rst) q_valid <= 1'b0;
    else if (ready) q_valid <= valid;
    if (ready && valid) q_item <= it;
  end

endmodule

// ----- design/soalu_fifo.sv -----
// ----------------------------------------------------------------------------
// soalu_fifo: item queue
// Small register queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module soalu_fifo #(
  parameter int DEPTH = soalu_pkg::QDEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  soalu_pkg::item_t in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output soalu_pkg::item_t out_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  soalu_pkg::item_t mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   cnt;
  logic          push, pop;

  assign in_ready  = cnt != (AW+1)'(DEPTH);
  assign out_valid = cnt != '0;
  assign out_item  = mem[rp];
  assign push      = in_valid & in_ready;
  assign pop       = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= (wp == AW'(DEPTH-1)) ? '0 : wp + 1'b1;
      if (pop)  rp <= (rp == AW'(DEPTH-1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (AW+1)'(push) - (AW+1)'(pop);
    end
    if (push) mem[wp] <= in_item;
  end

endmodule

// ----- design/soalu_back.sv -----
// ----------------------------------------------------------------------------
// soalu_back: execution pipeline
// Multiplier and a radix-2 divider unrolled one quotient bit per stage.
// ----------------------------------------------------------------------------
module soalu_back #(
  parameter int DIGITS = soalu_pkg::DIGITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  soalu_pkg::item_t            in_item,
  output logic                        valid,
  input  logic                        ready,
  output logic [1:0]                  status,
  output logic                        result_negative,
  output logic [soalu_pkg::MAG_W-1:0] result_magnitude,
  output logic [soalu_pkg::MAG_W-1:0] remainder_magnitude
);

  localparam int W  = soalu_pkg::MAG_W;
  localparam int NS = W + 1;  // stage 1 multiply, then W divide steps
  localparam int LW = 3 * DIGITS;
  localparam logic [2*W:0] LIM = (2*W+1)'({LW{1'b1}});

  logic             v   [NS+1];
  soalu_pkg::item_t s   [NS+1];
  logic [W-1:0]     rem [NS+1];
  logic [W-1:0]     quo [NS+1];
  logic [2*W-1:0]   prod;
  logic             adv;

  // Whole pipe moves together; a held result stalls everything.
  assign adv      = ~valid | ready;
  assign in_ready = adv;
  assign v[0]   = in_valid;
  assign s[0]   = in_item;
  assign rem[0] = '0;
  assign quo[0] = in_item.a_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= NS; i++) v[i] <= 1'b0;
    end else if (adv) begin
      for (int i = 1; i <= NS; i++) v[i] <= v[i-1];
    end
  end

  // Stage 1: product register.
  always_ff @(posedge clk) begin
    if (adv) begin
      prod   <= s[0].a_mag * s[0].b_mag;
      s[1]   <= s[0];
      rem[1] <= rem[0];
      quo[1] <= quo[0];
    end
  end

  // Stages 2..W+1: one restoring division step each.
  for (genvar g = 1; g <= W; g++) begin : g_div
    logic [W:0] trial;
    always_comb trial = {rem[g], quo[g][W-1]} - {1'b0, s[g].b_mag};
    always_ff @(posedge clk) begin
      if (adv) begin
        s[g+1] <= s[g];
        if (!trial[W]) begin
          rem[g+1] <= trial[W-1:0];
          quo[g+1] <= {quo[g][W-2:0], 1'b1};
        end else begin
          rem[g+1] <= {rem[g][W-2:0], quo[g][W-1]};
          quo[g+1] <= {quo[g][W-2:0], 1'b0};
        end
      end
    end
  end

  // Product captured at stage 1 rides alongside the divider stages.
  logic [2*W-1:0] pd [NS+1];
  assign pd[1] = prod;
  for (genvar g = 1; g < NS; g++) begin : g_pd
    always_ff @(posedge clk) if (adv) pd[g+1] <= pd[g];
  end

  // Final stage: sign rules, overflow and output register.
  soalu_pkg::item_t f;
  logic [W:0]   q1;
  logic [W-1:0] r1;
  logic         qn;
  logic [1:0]   st;
  logic         rn;
  logic [W-1:0] rm, rr;

  always_comb begin
    f  = s[NS];
    q1 = {1'b0, quo[NS]};
    r1 = rem[NS];
    qn = 1'b0;
    st = f.status;
    rn = f.neg;
    rm = f.mag;
    rr = '0;
    case (f.op)
      soalu_pkg::OP_MUL: begin
        if ({1'b0, pd[NS]} > LIM) begin
          st = soalu_pkg::ST_OVERFLOW;
          rn = 1'b0;
          rm = '0;
        end else begin
          rn = f.a_neg ^ f.b_neg;
          rm = W'(pd[NS]);
        end
      end
      soalu_pkg::OP_DIV: begin
        if (f.a_neg && !f.b_neg) begin
          if (r1 != '0) begin
            q1 = q1 + 1'b1;
            r1 = f.b_mag - r1;
          end
          qn = 1'b1;
        end else if (!f.a_neg && f.b_neg) begin
          qn = 1'b1;
        end
        if ((2*W+1)'(q1) > LIM) begin
          st = soalu_pkg::ST_OVERFLOW;
          rn = 1'b0;
          rm = '0;
        end else begin
          rn = qn;
          rm = q1[W-1:0];
          rr = r1;
        end
      end
      default: ;
    endcase
    if (rm == '0) rn = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) valid <= 1'b0;
    else if (adv) valid <= v[NS];
    if (adv) begin
      status              <= st;
      result_negative     <= rn;
      result_magnitude    <= rm;
      remainder_magnitude <= rr;
    end
  end

endmodule
